// ===== hw/rtl/dbas_pkg.sv =====
// Package for the debounced auto-repeat stepper: item types, register
// indexes, timing configuration and per-button status structs.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package dbas_pkg;

    // Widths fixed by the item fields and registers
    localparam int StampW  = 32;
    localparam int TimeW   = 16;
    localparam int StepW   = 13;
    localparam int OutPosW = 12;
    localparam int PosW    = 16;   // holds any position limit in range
    localparam int CfgAddrW = 3;
    localparam int CfgDataW = 16;

    // Register indexes
    localparam logic [CfgAddrW-1:0] RegRepeatDelay = 3'd0;
    localparam logic [CfgAddrW-1:0] RegFastAfter   = 3'd1;
    localparam logic [CfgAddrW-1:0] RegSlowPeriod  = 3'd2;
    localparam logic [CfgAddrW-1:0] RegFastPeriod  = 3'd3;
    localparam logic [CfgAddrW-1:0] RegUpSlowStep  = 3'd4;
    localparam logic [CfgAddrW-1:0] RegUpFastStep  = 3'd5;
    localparam logic [CfgAddrW-1:0] RegDnSlowStep  = 3'd6;
    localparam logic [CfgAddrW-1:0] RegDnFastStep  = 3'd7;

    // Register reset values
    localparam logic [TimeW-1:0]        RstRepeatDelay = 16'd500;
    localparam logic [TimeW-1:0]        RstFastAfter   = 16'd2000;
    localparam logic [TimeW-1:0]        RstSlowPeriod  = 16'd100;
    localparam logic [TimeW-1:0]        RstFastPeriod  = 16'd30;
    localparam logic signed [StepW-1:0] RstUpSlowStep  = 13'sd1;
    localparam logic signed [StepW-1:0] RstUpFastStep  = 13'sd10;
    localparam logic signed [StepW-1:0] RstDnSlowStep  = -13'sd1;
    localparam logic signed [StepW-1:0] RstDnFastStep  = -13'sd10;

    // Parameter defaults
    localparam int DefDebounceMs   = 20;
    localparam int DefInvertLevels = 0;
    localparam int DefPosMin       = -2048;
    localparam int DefPosMax       = 2047;

    typedef struct packed {
        logic [StampW-1:0] now_ms;
        logic              up_level;
        logic              down_level;
    } in_item_t;

    typedef struct packed {
        logic                      moved;
        logic signed [OutPosW-1:0] position;
        logic                      up_held;
        logic                      down_held;
    } out_item_t;

    typedef struct packed {
        logic [TimeW-1:0] repeat_delay_ms;
        logic [TimeW-1:0] fast_after_ms;
        logic [TimeW-1:0] slow_period_ms;
        logic [TimeW-1:0] fast_period_ms;
    } timing_cfg_t;

    typedef struct packed {
        logic step_ev;   // button makes a step this sample
        logic fast;      // fast repeating after this sample
        logic held;      // debounced pressed state after this sample
    } btn_stat_t;

endpackage
`default_nettype wire

// ===== hw/rtl/dbas_button.sv =====
// One button: level inversion, time debounce and auto-repeat timing.
// Depends on dbas_pkg.
`timescale 1ns / 1ps
`default_nettype none
module dbas_button #(
    parameter int DEBOUNCE_MS   = dbas_pkg::DefDebounceMs,
    parameter int INVERT_LEVELS = dbas_pkg::DefInvertLevels
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          en,
    input  wire logic [dbas_pkg::StampW-1:0]   now_ms,
    input  wire logic                          raw_level,
    input  wire dbas_pkg::timing_cfg_t         tcfg,
    output dbas_pkg::btn_stat_t                stat
);

    localparam logic [dbas_pkg::StampW-1:0] DebTicks = dbas_pkg::StampW'(DEBOUNCE_MS);
    localparam logic                        InvBit   = 1'(INVERT_LEVELS);

    logic                          last_level_reg, last_level_next;
    logic [dbas_pkg::StampW-1:0]   change_stamp_reg, change_stamp_next;
    logic                          held_reg, held_next;
    logic [dbas_pkg::StampW-1:0]   press_stamp_reg, press_stamp_next;
    logic [dbas_pkg::StampW-1:0]   repeat_stamp_reg, repeat_stamp_next;
    logic                          repeating_reg, repeating_next;
    logic                          fast_reg, fast_next;

    logic                          lvl;
    logic [dbas_pkg::StampW-1:0]   since_change;
    logic [dbas_pkg::StampW-1:0]   since_press;
    logic [dbas_pkg::StampW-1:0]   since_rep;
    logic                          deb_flip;
    logic                          fresh;
    logic                          rep1;
    logic                          fast1;
    logic                          fast2;
    logic                          ev;

    always_comb begin
        lvl = raw_level ^ InvBit;

        // A level change restarts the debounce window at zero
        since_change = (lvl != last_level_reg) ? '0 : (now_ms - change_stamp_reg);
        deb_flip     = (since_change >= DebTicks) && (lvl != held_reg);
        fresh        = deb_flip && lvl;

        held_next         = deb_flip ? lvl : held_reg;
        rep1              = deb_flip ? 1'b0 : repeating_reg;
        fast1             = deb_flip ? 1'b0 : fast_reg;
        press_stamp_next  = fresh ? now_ms : press_stamp_reg;
        last_level_next   = lvl;
        change_stamp_next = (lvl != last_level_reg) ? now_ms : change_stamp_reg;

        // A fresh press stamps now, so both elapsed times are zero
        since_press = fresh ? '0 : (now_ms - press_stamp_reg);
        since_rep   = fresh ? '0 : (now_ms - repeat_stamp_reg);

        ev                = fresh;
        repeating_next    = rep1;
        fast2             = fast1;
        repeat_stamp_next = fresh ? now_ms : repeat_stamp_reg;

        if (held_next) begin
            if (!rep1 && (since_press >= dbas_pkg::StampW'(tcfg.repeat_delay_ms))) begin
                repeating_next    = 1'b1;
                repeat_stamp_next = now_ms;
                ev                = 1'b1;
            end else if (rep1) begin
                fast2 = fast1 | (since_press >= dbas_pkg::StampW'(tcfg.fast_after_ms));
                if (since_rep >= dbas_pkg::StampW'(fast2 ? tcfg.fast_period_ms
                                                         : tcfg.slow_period_ms)) begin
                    repeat_stamp_next = now_ms;
                    ev                = 1'b1;
                end
            end
        end
        fast_next = fast2;

        stat.step_ev = ev;
        stat.fast    = fast2;
        stat.held    = held_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_level_reg   <= 1'b0;
            change_stamp_reg <= '0;
            held_reg         <= 1'b0;
            press_stamp_reg  <= '0;
            repeat_stamp_reg <= '0;
            repeating_reg    <= 1'b0;
            fast_reg         <= 1'b0;
        end else if (en) begin
            last_level_reg   <= last_level_next;
            change_stamp_reg <= change_stamp_next;
            held_reg         <= held_next;
            press_stamp_reg  <= press_stamp_next;
            repeat_stamp_reg <= repeat_stamp_next;
            repeating_reg    <= repeating_next;
            fast_reg         <= fast_next;
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/dbas_accum.sv =====
// Position accumulator: adds the up step then the down step, clamping each sum.
// Depends on dbas_pkg.
`timescale 1ns / 1ps
`default_nettype none
module dbas_accum #(
    parameter int POS_MIN = dbas_pkg::DefPosMin,
    parameter int POS_MAX = dbas_pkg::DefPosMax
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                en,
    input  wire logic                                up_ev,
    input  wire logic signed [dbas_pkg::StepW-1:0]   up_step,
    input  wire logic                                dn_ev,
    input  wire logic signed [dbas_pkg::StepW-1:0]   dn_step,
    output logic signed [dbas_pkg::OutPosW-1:0]      position
);

    localparam int SumW = dbas_pkg::PosW + 1;
    localparam logic signed [SumW-1:0] MinS = SumW'(POS_MIN);
    localparam logic signed [SumW-1:0] MaxS = SumW'(POS_MAX);

    logic signed [dbas_pkg::PosW-1:0] pos_reg, pos_next;
    logic signed [dbas_pkg::PosW-1:0] pos_mid;
    logic signed [SumW-1:0]           sum_up, sum_dn;

    function automatic logic signed [dbas_pkg::PosW-1:0] clamp(
        input logic signed [SumW-1:0] s
    );
        logic signed [SumW-1:0] c;
        if (s < MinS)
            c = MinS;
        else if (s > MaxS)
            c = MaxS;
        else
            c = s;
        return c[dbas_pkg::PosW-1:0];
    endfunction

    always_comb begin
        sum_up   = SumW'(pos_reg) + SumW'(up_step);
        pos_mid  = up_ev ? clamp(sum_up) : pos_reg;
        sum_dn   = SumW'(pos_mid) + SumW'(dn_step);
        pos_next = dn_ev ? clamp(sum_dn) : pos_mid;
        position = pos_next[dbas_pkg::OutPosW-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= '0;
        end else if (en) begin
            pos_reg <= pos_next;
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/debounced_autorepeat_stepper.sv =====
// Debounced two-button auto-repeat stepper, top level.
// Each sample passes the input register, then the result register, which holds while m_ready is low.
// Throughput: one item per cycle while m_ready is high; the result register frees the input side as it drains.
// Reset (aresetn low, synchronous): registers to defaults, buttons released, position zero.
// Depends on dbas_pkg, dbas_button, dbas_accum.
`timescale 1ns / 1ps
`default_nettype none
module debounced_autorepeat_stepper #(
    parameter int DEBOUNCE_MS   = dbas_pkg::DefDebounceMs,
    parameter int INVERT_LEVELS = dbas_pkg::DefInvertLevels,
    parameter int POS_MIN       = dbas_pkg::DefPosMin,
    parameter int POS_MAX       = dbas_pkg::DefPosMax
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // sample input
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire dbas_pkg::in_item_t                s_data,
    // result output
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output dbas_pkg::out_item_t                    m_data,
    // configuration writes
    input  wire logic                              cfg_wr_en,
    input  wire logic [dbas_pkg::CfgAddrW-1:0]     cfg_addr,
    input  wire logic [dbas_pkg::CfgDataW-1:0]     cfg_wdata
);

    // Configuration registers
    dbas_pkg::timing_cfg_t                  tcfg_reg;
    logic signed [dbas_pkg::StepW-1:0]      up_slow_reg, up_fast_reg;
    logic signed [dbas_pkg::StepW-1:0]      dn_slow_reg, dn_fast_reg;

    // Input register stage
    logic                                   in_valid_reg;
    dbas_pkg::in_item_t                     in_data_reg;

    // Result register stage
    logic                                   out_valid_reg;
    dbas_pkg::out_item_t                    out_data_reg;

    logic                                   out_free;
    logic                                   advance;
    dbas_pkg::btn_stat_t                    up_stat, dn_stat;
    logic signed [dbas_pkg::StepW-1:0]      up_step, dn_step;
    logic signed [dbas_pkg::OutPosW-1:0]    pos_now;

    // Handshake: the result register empties or drains this cycle, so the
    // held sample can move on and the input register can take a new item.
    assign out_free = !out_valid_reg || m_ready;
    assign advance  = in_valid_reg && out_free;
    assign s_ready  = !in_valid_reg || out_free;
    assign m_valid  = out_valid_reg;
    assign m_data   = out_data_reg;

    // Configuration write decode; the data is cut to each register's width
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tcfg_reg.repeat_delay_ms <= dbas_pkg::RstRepeatDelay;
            tcfg_reg.fast_after_ms   <= dbas_pkg::RstFastAfter;
            tcfg_reg.slow_period_ms  <= dbas_pkg::RstSlowPeriod;
            tcfg_reg.fast_period_ms  <= dbas_pkg::RstFastPeriod;
            up_slow_reg              <= dbas_pkg::RstUpSlowStep;
            up_fast_reg              <= dbas_pkg::RstUpFastStep;
            dn_slow_reg              <= dbas_pkg::RstDnSlowStep;
            dn_fast_reg              <= dbas_pkg::RstDnFastStep;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                dbas_pkg::RegRepeatDelay: tcfg_reg.repeat_delay_ms <= cfg_wdata;
                dbas_pkg::RegFastAfter:   tcfg_reg.fast_after_ms   <= cfg_wdata;
                dbas_pkg::RegSlowPeriod:  tcfg_reg.slow_period_ms  <= cfg_wdata;
                dbas_pkg::RegFastPeriod:  tcfg_reg.fast_period_ms  <= cfg_wdata;
                dbas_pkg::RegUpSlowStep:  up_slow_reg <= cfg_wdata[dbas_pkg::StepW-1:0];
                dbas_pkg::RegUpFastStep:  up_fast_reg <= cfg_wdata[dbas_pkg::StepW-1:0];
                dbas_pkg::RegDnSlowStep:  dn_slow_reg <= cfg_wdata[dbas_pkg::StepW-1:0];
                dbas_pkg::RegDnFastStep:  dn_fast_reg <= cfg_wdata[dbas_pkg::StepW-1:0];
                default: ;
            endcase
        end
    end

    // Input register: hold the sample until the result register takes it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_data_reg <= s_data;
        end
    end

    // Per-button debounce and repeat timing; state advances with the sample
    dbas_button #(
        .DEBOUNCE_MS   (DEBOUNCE_MS),
        .INVERT_LEVELS (INVERT_LEVELS)
    ) u_btn_up (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (advance),
        .now_ms    (in_data_reg.now_ms),
        .raw_level (in_data_reg.up_level),
        .tcfg      (tcfg_reg),
        .stat      (up_stat)
    );

    dbas_button #(
        .DEBOUNCE_MS   (DEBOUNCE_MS),
        .INVERT_LEVELS (INVERT_LEVELS)
    ) u_btn_dn (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (advance),
        .now_ms    (in_data_reg.now_ms),
        .raw_level (in_data_reg.down_level),
        .tcfg      (tcfg_reg),
        .stat      (dn_stat)
    );

    // Step size follows the fast state left by this sample
    assign up_step = up_stat.fast ? up_fast_reg : up_slow_reg;
    assign dn_step = dn_stat.fast ? dn_fast_reg : dn_slow_reg;

    // Up step first, clamp, then down step, clamp
    dbas_accum #(
        .POS_MIN (POS_MIN),
        .POS_MAX (POS_MAX)
    ) u_accum (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (advance),
        .up_ev    (up_stat.step_ev),
        .up_step  (up_step),
        .dn_ev    (dn_stat.step_ev),
        .dn_step  (dn_step),
        .position (pos_now)
    );

    // Result register: load on advance, drop valid once taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_data_reg.moved     <= up_stat.step_ev | dn_stat.step_ev;
            out_data_reg.position  <= pos_now;
            out_data_reg.up_held   <= up_stat.held;
            out_data_reg.down_held <= dn_stat.held;
        end
    end

endmodule
`default_nettype wire
